FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_CLK_NO_RESET(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/mbps_pkg.sv
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared constants, register codes and types of the masked byte search.
// ----------------------------------------------------------------------------
`default_nettype none

package mbps_pkg;

   // Defaults of the top-level parameters
   localparam int unsigned MAX_PATTERN_BYTES_DEFAULT = 16;
   localparam int unsigned OFFSET_BITS_DEFAULT       = 26;

   // Fixed field widths
   localparam int unsigned BYTE_W            = 8;
   localparam int unsigned PATTERN_REG_BYTES = 16;
   localparam int unsigned PAT_SEL_W         = $clog2(PATTERN_REG_BYTES);
   localparam int unsigned LENGTH_W          = 5;
   localparam int unsigned HITS_W            = 12;
   localparam int unsigned CSR_INDEX_W       = 3;
   localparam int unsigned CSR_DATA_W        = 64;
   localparam int unsigned HALF_PATTERN_W    = 64;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_LOW  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_HIGH = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_BYTE_MASK    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_LEN  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_HITS     = 3'd4;

   // Register reset values
   localparam logic [PATTERN_REG_BYTES-1:0] MASK_RESET     = '1;
   localparam logic [LENGTH_W-1:0]          LENGTH_RESET   = 5'd1;
   localparam logic [HITS_W-1:0]            MAX_HITS_RESET = 12'd12;

   // Pattern setup seen by every compare cell
   typedef struct packed {
      logic [PATTERN_REG_BYTES-1:0][BYTE_W-1:0] pattern;
      logic [PATTERN_REG_BYTES-1:0]             mask;
      logic [LENGTH_W-1:0]                      length;
   } match_cfg_type;

endpackage

`default_nettype wire

FILE: design/mbps_if.sv
// ----------------------------------------------------------------------------
// mbps_if
// Valid/ready channels of the masked byte search: bytes in, hits out, CSR.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbps_req_if;
   import mbps_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] byte_value;
   logic              last_byte;

   modport source (output valid, output byte_value, output last_byte, input ready);
   modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface mbps_rsp_if #(
   parameter int unsigned OFFSET_BITS = mbps_pkg::OFFSET_BITS_DEFAULT
);
   import mbps_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [OFFSET_BITS-1:0] hit_offset;
   logic [HITS_W-1:0]      hit_index;

   modport source (output valid, output hit_offset, output hit_index, input ready);
   modport sink   (input valid, input hit_offset, input hit_index, output ready);
endinterface

interface mbps_csr_if;
   import mbps_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: design/mbps_cell.sv
// ----------------------------------------------------------------------------
// mbps_cell
// One window byte of the search chain and its masked compare.
// ----------------------------------------------------------------------------
`default_nettype none

module mbps_cell #(
   parameter int unsigned CELL_INDEX = 0
) (
   input  logic                              clock,
   input  logic                              shift_en,
   input  logic [mbps_pkg::BYTE_W-1:0]       neighbor_byte,
   input  mbps_pkg::match_cfg_type           cfg,
   output logic [mbps_pkg::BYTE_W-1:0]       byte_out,
   output logic                              match_ok
);
   import mbps_pkg::*;

   logic [BYTE_W-1:0]   byte_ff;
   logic [BYTE_W-1:0]   byte_in;
   logic                in_use;
   logic [LENGTH_W-1:0] pat_sel;
   logic                care;

   // Take the neighbor's byte on every accepted beat
   assign byte_in = shift_en ? neighbor_byte : byte_ff;

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign byte_out = byte_ff;

   // This cell holds pattern byte (length - 1 - CELL_INDEX) after the shift
   assign in_use  = 32'(CELL_INDEX) < 32'(cfg.length);
   assign pat_sel = cfg.length - LENGTH_W'(1) - LENGTH_W'(CELL_INDEX);
   assign care    = in_use && (pat_sel < LENGTH_W'(PATTERN_REG_BYTES)) &&
                    cfg.mask[pat_sel[PAT_SEL_W-1:0]];

   // Compare the byte that lands here on this beat
   assign match_ok = !care || (neighbor_byte == cfg.pattern[pat_sel[PAT_SEL_W-1:0]]);

endmodule

`default_nettype wire

FILE: design/mbps_out_queue.sv
// ----------------------------------------------------------------------------
// mbps_out_queue
// Two-entry result buffer between the match chain and the hit channel.
// ----------------------------------------------------------------------------
`default_nettype none

module mbps_out_queue #(
   parameter int unsigned DATA_W = 38
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   input  logic              pop_ready,
   output logic              out_valid,
   output logic [DATA_W-1:0] out_data,
   output logic              has_room
);
   import mbps_pkg::*;

   localparam int unsigned DEPTH = 2;
   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              pop;

   assign pop       = out_valid && pop_ready;
   assign out_valid = count_ff != '0;
   assign has_room  = count_ff != CNT_W'(DEPTH);
   assign out_data  = entry_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store a new hit
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

FILE: design/masked_byte_pattern_search_top.sv
// ----------------------------------------------------------------------------
// masked_byte_pattern_search_top
// Streaming search for a masked byte pattern with non-overlapping hits.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle and never needs more: each byte
// shifts into a chain of MAX_PATTERN_BYTES compare cells, every cell checks
// its byte against its pattern byte in the same cycle, and a hit for the byte
// is registered in the result buffer before the response channel shows it.
// Hits wait in a two-entry buffer, so the byte channel stalls only while two
// hits are held and unread. Offsets count from zero in each buffer and stop
// at 2^OFFSET_BITS-1; a byte marked last resets offset, hit count and overlap
// point for the next buffer. Configuration takes effect from the next byte.
// ----------------------------------------------------------------------------
`default_nettype none

module masked_byte_pattern_search_top #(
   parameter int unsigned MAX_PATTERN_BYTES = mbps_pkg::MAX_PATTERN_BYTES_DEFAULT,
   parameter int unsigned OFFSET_BITS       = mbps_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   mbps_req_if.sink     req_bus,
   mbps_rsp_if.source   rsp_bus,
   mbps_csr_if.sink     csr_bus
);
   import mbps_pkg::*;

   localparam int unsigned POS_W  = OFFSET_BITS + 1;
   localparam int unsigned DATA_W = OFFSET_BITS + HITS_W;
   localparam logic [OFFSET_BITS-1:0] CEILING = '1;

   // Configuration registers
   logic [HALF_PATTERN_W-1:0]    pat_low_ff;
   logic [HALF_PATTERN_W-1:0]    pat_high_ff;
   logic [PATTERN_REG_BYTES-1:0] mask_ff;
   logic [LENGTH_W-1:0]          length_ff;
   logic [HITS_W-1:0]            max_hits_ff;

   // Scan state
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic [POS_W-1:0]       earliest_ff, earliest_in;
   logic [HITS_W-1:0]      hits_ff, hits_in;

   logic                              accept;
   logic [LENGTH_W-1:0]               length_eff;
   match_cfg_type                     match_cfg;
   logic [MAX_PATTERN_BYTES-1:0][BYTE_W-1:0] chain_byte;
   logic [MAX_PATTERN_BYTES-1:0]      cell_ok;
   logic [POS_W-1:0]                  pos_plus1;
   logic [POS_W-1:0]                  length_ext;
   logic [POS_W-1:0]                  start;
   logic                              hit;
   logic                              queue_room;
   logic [DATA_W-1:0]                 queue_out;

   // Configuration writes
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         mask_ff     <= MASK_RESET;
         length_ff   <= LENGTH_RESET;
         max_hits_ff <= MAX_HITS_RESET;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            REG_PATTERN_LOW:  pat_low_ff  <= csr_bus.data;
            REG_PATTERN_HIGH: pat_high_ff <= csr_bus.data;
            REG_BYTE_MASK:    mask_ff     <= csr_bus.data[PATTERN_REG_BYTES-1:0];
            REG_PATTERN_LEN:  length_ff   <= csr_bus.data[LENGTH_W-1:0];
            REG_MAX_HITS:     max_hits_ff <= csr_bus.data[HITS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Clamp the length to the chain size
   assign length_eff = (32'(length_ff) > 32'(MAX_PATTERN_BYTES)) ?
                       LENGTH_W'(MAX_PATTERN_BYTES) : length_ff;

   assign match_cfg.pattern = {pat_high_ff, pat_low_ff};
   assign match_cfg.mask    = mask_ff;
   assign match_cfg.length  = length_eff;

   assign accept        = req_bus.valid && req_bus.ready;
   assign req_bus.ready = queue_room;

   // Compare chain, newest byte in cell zero
   for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cell
      logic [BYTE_W-1:0] from_left;
      if (k == 0) begin : g_head
         assign from_left = req_bus.byte_value;
      end else begin : g_body
         assign from_left = chain_byte[k-1];
      end

      mbps_cell #(
         .CELL_INDEX (k)
      ) u_cell (
         .clock         (clock),
         .shift_en      (accept),
         .neighbor_byte (from_left),
         .cfg           (match_cfg),
         .byte_out      (chain_byte[k]),
         .match_ok      (cell_ok[k])
      );
   end

   // Hit qualification
   assign pos_plus1  = {1'b0, pos_ff} + POS_W'(1);
   assign length_ext = POS_W'(length_eff);
   assign start      = pos_plus1 - length_ext;

   assign hit = accept && (length_eff != '0) && (pos_ff != CEILING) &&
                (pos_plus1 >= length_ext) && (hits_ff < max_hits_ff) &&
                (start >= earliest_ff) && (&cell_ok);

   // Advance position, hit count and overlap point; drop them on the last byte
   always_comb begin
      pos_in      = pos_ff;
      earliest_in = earliest_ff;
      hits_in     = hits_ff;
      if (accept) begin
         if (req_bus.last_byte) begin
            pos_in      = '0;
            earliest_in = '0;
            hits_in     = '0;
         end else begin
            if (pos_ff != CEILING) begin
               pos_in = pos_ff + OFFSET_BITS'(1);
            end
            if (hit) begin
               earliest_in = pos_plus1;
               hits_in     = hits_ff + HITS_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         earliest_ff <= '0;
         hits_ff     <= '0;
      end else begin
         pos_ff      <= pos_in;
         earliest_ff <= earliest_in;
         hits_ff     <= hits_in;
      end
   end

   // Result buffer
   mbps_out_queue #(
      .DATA_W (DATA_W)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (hit),
      .push_data ({start[OFFSET_BITS-1:0], hits_ff}),
      .pop_ready (rsp_bus.ready),
      .out_valid (rsp_bus.valid),
      .out_data  (queue_out),
      .has_room  (queue_room)
   );

   assign rsp_bus.hit_offset = queue_out[DATA_W-1:HITS_W];
   assign rsp_bus.hit_index  = queue_out[HITS_W-1:0];

endmodule

`default_nettype wire

FILE: design/mbps_checker.sv
// ----------------------------------------------------------------------------
// mbps_checker
// Port-level checks of the masked byte search, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mbps_checker #(
   parameter int unsigned OFFSET_BITS = mbps_pkg::OFFSET_BITS_DEFAULT
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [OFFSET_BITS-1:0]        hit_offset,
   input logic [mbps_pkg::HITS_W-1:0]   hit_index
);
   import mbps_pkg::*;

   // Reset empties the result buffer
   `ASSERT_CLK_NO_RESET(a_reset_empties, clock, reset |=> !rsp_valid, "hit pending after reset")

   // Byte stalls come only from unread hits
   `ASSERT_CLK(a_stall_needs_hit, clock, reset, !req_ready |-> rsp_valid, "stall without pending hit")

   // Hold a stalled hit beat
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "hit beat dropped")

   `ASSERT_CLK(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(hit_offset) && $stable(hit_index), "hit beat changed while stalled")

endmodule

bind masked_byte_pattern_search_top mbps_checker #(
   .OFFSET_BITS (OFFSET_BITS)
) u_mbps_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .hit_offset (rsp_bus.hit_offset),
   .hit_index  (rsp_bus.hit_index)
);

`default_nettype wire
